[sv/udpdm_pkg.sv]
// ----------------------------------------------------------------------------
// UDP port demux ring writer - shared definitions
// Sizes, item kinds and the structs passed between the control, the socket
// table memory and the top level.
// ----------------------------------------------------------------------------
package udpdm_pkg;

	localparam int SOCKETS   = 64;
	localparam int BUF_BYTES = 1024;
	localparam int SOCK_W    = $clog2(SOCKETS);
	localparam int POS_W     = $clog2(BUF_BYTES);
	localparam int HDR_LEN   = 8;
	localparam int META_LEN  = 8;
	localparam int META_W    = $clog2(META_LEN);

	typedef enum logic [1:0] {
		FUNC_BYTE      = 2'd0,
		FUNC_SET_ENTRY = 2'd1,
		FUNC_READ_POS  = 2'd2,
		FUNC_NONE      = 2'd3
	} func_t;

	// Input word, last field (data_byte) in the lowest bits.
	typedef struct packed {
		logic [5:0]  pad;
		logic [9:0]  read_pos;
		logic [15:0] sock_port;
		logic        sock_is_udp;
		logic        sock_valid;
		logic [5:0]  sock_index;
		logic [31:0] source_address;
		logic [15:0] datagram_len;
		logic [7:0]  data_byte;
	} item_t;

	// One socket table entry.
	typedef struct packed {
		logic             valid;
		logic             udp;
		logic [15:0]      port;
		logic [POS_W-1:0] wpos;
		logic [POS_W-1:0] rpos;
	} ent_t;

	typedef struct packed {
		logic              rd_en;
		logic [SOCK_W-1:0] rd_addr;
		logic              wr_en;
		logic [SOCK_W-1:0] wr_addr;
		ent_t              wdata;
	} ram_req_t;

	typedef struct packed {
		logic       write_valid;
		logic [5:0] sock_num;
		logic [9:0] buf_pos;
		logic [7:0] buf_byte;
		logic       wake;
		logic       last;
	} res_t;

endpackage

[sv/udpdm_sock_ram.sv]
// ----------------------------------------------------------------------------
// Socket table memory
// One entry per socket: flags, bound port, ring write and read positions.
// Synchronous read: the entry shows in the cycle after its read request; an
// entry never written reads as all zero through a per-entry written bit.
// ----------------------------------------------------------------------------
module udpdm_sock_ram (
	input  logic                clk,
	input  logic                arst_n,
	input  udpdm_pkg::ram_req_t req,
	output udpdm_pkg::ent_t     rdata
);
	import udpdm_pkg::*;

	ent_t               mem_q [SOCKETS];
	logic [SOCKETS-1:0] written_q;
	ent_t               rd_q;
	logic               rd_written_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_q <= mem_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				written_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_written_q <= written_q[req.rd_addr];
			end
		end
	end

	assign rdata = rd_written_q ? rd_q : '0;

endmodule

[sv/udpdm_ctrl.sv]
// ----------------------------------------------------------------------------
// UDP port demux control
// Parses the UDP header, searches the socket table for the destination
// port, checks ring room and sequences the metadata and payload writes.
// All socket state is read, modified and written back in the table memory.
// ----------------------------------------------------------------------------
module udpdm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  udpdm_pkg::item_t    item,
	input  udpdm_pkg::func_t    func,
	input  logic                first_byte,
	output udpdm_pkg::ram_req_t ram_req,
	input  udpdm_pkg::ent_t     ram_rdata,
	output logic                res_valid,
	input  logic                res_ready,
	output udpdm_pkg::res_t     res
);
	import udpdm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESULT,
		ST_CFG,
		ST_SEARCH,
		ST_META,
		ST_PAY
	} state_t;

	state_t            state_q;
	item_t             item_q;
	func_t             func_q;
	logic              accepting_q;
	logic [15:0]       count_q;
	logic [47:0]       hdr_q;
	logic [SOCK_W-1:0] matched_q;
	logic [SOCK_W-1:0] srch_q;
	logic [META_W-1:0] meta_q;
	logic [POS_W-1:0]  wpos_q;
	ent_t              ent_q;
	logic              wake_q;

	// decisions on the incoming word
	logic        acc_c;
	logic [15:0] cnt_c;
	logic [47:0] hdr_c;
	logic [15:0] ulen_c;
	logic        in_range_c;
	logic        go_search_c;
	logic        go_pay_c;
	logic        pay_wake_c;

	// search and room check
	logic             hit_c;
	logic             srch_last_c;
	logic [POS_W-1:0] diff_c;
	logic [POS_W:0]   free_c;
	logic [15:0]      plen_c;
	logic [16:0]      need_c;
	logic             room_c;
	logic             meta_last_c;
	logic [7:0]       meta_byte_c;

	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		acc_c      = first_byte ? (item.datagram_len >= 16'(HDR_LEN)) : accepting_q;
		cnt_c      = first_byte ? 16'd0 : count_q;
		hdr_c      = first_byte ? 48'd0 : hdr_q;
		ulen_c     = hdr_c[15:0];
		in_range_c = (32'(item.sock_index) < SOCKETS);
		go_search_c = (func == FUNC_BYTE) && acc_c && (cnt_c == 16'(HDR_LEN - 1)) &&
			!(item.datagram_len < ulen_c || ulen_c < 16'(HDR_LEN));
		go_pay_c   = (func == FUNC_BYTE) && acc_c && (cnt_c >= 16'(HDR_LEN)) &&
			(cnt_c < ulen_c);
		pay_wake_c = ((17'(cnt_c) + 17'd1) == 17'(ulen_c));
	end

	always_comb begin
		hit_c       = ram_rdata.valid && ram_rdata.udp && (ram_rdata.port == hdr_q[31:16]);
		srch_last_c = (srch_q == SOCK_W'(SOCKETS - 1));
		diff_c      = ram_rdata.wpos - ram_rdata.rpos;
		free_c      = (POS_W + 1)'(BUF_BYTES) - {1'b0, diff_c};
		plen_c      = hdr_q[15:0] - 16'(HDR_LEN);
		need_c      = 17'(plen_c) + 17'(HDR_LEN + 1);
		room_c      = (17'(free_c) > need_c);
		meta_last_c = (meta_q == META_W'(META_LEN - 1));
		case (meta_q)
			3'd0:    meta_byte_c = item_q.source_address[31:24];
			3'd1:    meta_byte_c = item_q.source_address[23:16];
			3'd2:    meta_byte_c = item_q.source_address[15:8];
			3'd3:    meta_byte_c = item_q.source_address[7:0];
			3'd4:    meta_byte_c = hdr_q[39:32];
			3'd5:    meta_byte_c = hdr_q[47:40];
			3'd6:    meta_byte_c = plen_c[7:0];
			default: meta_byte_c = plen_c[15:8];
		endcase
	end

	// memory requests
	always_comb begin
		ram_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if ((func == FUNC_SET_ENTRY || func == FUNC_READ_POS) && in_range_c) begin
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = SOCK_W'(item.sock_index);
					end else if (go_search_c) begin
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = '0;
					end else if (go_pay_c) begin
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = matched_q;
					end
				end
			end
			ST_SEARCH: begin
				ram_req.rd_en   = !hit_c && !srch_last_c;
				ram_req.rd_addr = srch_q + SOCK_W'(1);
			end
			ST_CFG: begin
				ram_req.wr_en   = res_ready;
				ram_req.wr_addr = SOCK_W'(item_q.sock_index);
				ram_req.wdata   = ram_rdata;
				if (func_q == FUNC_SET_ENTRY) begin
					ram_req.wdata.valid = item_q.sock_valid;
					ram_req.wdata.udp   = item_q.sock_is_udp;
					ram_req.wdata.port  = item_q.sock_port;
				end else begin
					ram_req.wdata.rpos = POS_W'(item_q.read_pos);
				end
			end
			ST_META: begin
				ram_req.wr_en      = res_ready && meta_last_c;
				ram_req.wr_addr    = matched_q;
				ram_req.wdata      = ent_q;
				ram_req.wdata.wpos = wpos_q + POS_W'(1);
			end
			ST_PAY: begin
				ram_req.wr_en      = res_ready;
				ram_req.wr_addr    = matched_q;
				ram_req.wdata      = ram_rdata;
				ram_req.wdata.wpos = ram_rdata.wpos + POS_W'(1);
			end
			default: ram_req = '0;
		endcase
	end

	// result word
	always_comb begin
		res       = '0;
		res.last  = 1'b1;
		res_valid = 1'b0;
		case (state_q)
			ST_RESULT, ST_CFG: begin
				res_valid = 1'b1;
			end
			ST_META: begin
				res_valid       = 1'b1;
				res.write_valid = 1'b1;
				res.sock_num    = 6'(matched_q);
				res.buf_pos     = 10'(wpos_q);
				res.buf_byte    = meta_byte_c;
				res.wake        = meta_last_c && (plen_c == 16'd0);
				res.last        = meta_last_c;
			end
			ST_PAY: begin
				res_valid       = 1'b1;
				res.write_valid = 1'b1;
				res.sock_num    = 6'(matched_q);
				res.buf_pos     = 10'(ram_rdata.wpos);
				res.buf_byte    = item_q.data_byte;
				res.wake        = wake_q;
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			accepting_q <= 1'b0;
			count_q     <= '0;
			hdr_q       <= '0;
			matched_q   <= '0;
			srch_q      <= '0;
			meta_q      <= '0;
			wpos_q      <= '0;
			wake_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_RESULT;
						if (func == FUNC_BYTE) begin
							accepting_q <= acc_c;
							count_q     <= cnt_c;
							hdr_q       <= hdr_c;
							if (acc_c) begin
								if (cnt_c != 16'hFFFF) begin
									count_q <= cnt_c + 16'd1;
								end
								if (cnt_c < 16'(HDR_LEN - 2)) begin
									hdr_q <= {hdr_c[39:0], item.data_byte};
								end else if (cnt_c == 16'(HDR_LEN - 1)) begin
									if (go_search_c) begin
										state_q <= ST_SEARCH;
										srch_q  <= '0;
									end else begin
										accepting_q <= 1'b0;
									end
								end else if (cnt_c >= 16'(HDR_LEN)) begin
									if (go_pay_c) begin
										state_q <= ST_PAY;
										wake_q  <= pay_wake_c;
										if (pay_wake_c) begin
											accepting_q <= 1'b0;
										end
									end else begin
										accepting_q <= 1'b0;
									end
								end
							end
						end else if ((func == FUNC_SET_ENTRY || func == FUNC_READ_POS) &&
							in_range_c) begin
							state_q <= ST_CFG;
						end
					end
				end
				ST_SEARCH: begin
					if (hit_c) begin
						matched_q <= srch_q;
						wpos_q    <= ram_rdata.wpos;
						if (room_c) begin
							state_q <= ST_META;
							meta_q  <= '0;
						end else begin
							state_q     <= ST_RESULT;
							accepting_q <= 1'b0;
						end
					end else if (srch_last_c) begin
						state_q     <= ST_RESULT;
						accepting_q <= 1'b0;
					end else begin
						srch_q <= srch_q + SOCK_W'(1);
					end
				end
				ST_META: begin
					if (res_ready) begin
						wpos_q <= wpos_q + POS_W'(1);
						meta_q <= meta_q + META_W'(1);
						if (meta_last_c) begin
							state_q <= ST_IDLE;
							if (plen_c == 16'd0) begin
								accepting_q <= 1'b0;
							end
						end
					end
				end
				ST_RESULT, ST_CFG, ST_PAY: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// word and matched entry hold registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			item_q <= item;
			func_q <= func;
		end
		if (state_q == ST_SEARCH && hit_c) begin
			ent_q <= ram_rdata;
		end
	end

endmodule

[sv/udp_port_demux_ring_writer_top.sv]
// ----------------------------------------------------------------------------
// UDP port demux ring writer - top level
// Input words carry datagram bytes, socket entry updates or reader position
// updates. Each word gives one or more output words: ring writes, or a
// single idle word with write_valid low. tlast marks the last output word
// of an input word.
// A datagram byte, socket entry or reader position word is accepted in the idle
// state, which also issues any socket table read; a result state then gives
// its result. The eighth header byte searches up to 64 socket table entries,
// one entry per cycle through the memory's read port; on a hit with ring room
// it gives the 8 metadata writes at one per cycle unless the receiver stalls.
// The output word sits in a register, so a new input word is taken while
// the last result still waits; a stalled receiver stops the control at its
// next result, and the block takes no input until that result is placed.
// Reset empties the socket table at once through per-entry written bits,
// with no clearing pass; positions and the header parser start at zero.
// ----------------------------------------------------------------------------
module udp_port_demux_ring_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// data_byte, datagram_len, source_address, sock_index, sock_valid,
	// sock_is_udp, sock_port, read_pos, zero fill
	input  logic [95:0] s_tdata,
	// func, first_byte
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// sock_num, buf_pos, buf_byte
	output logic [23:0] m_tdata,
	// write_valid, wake
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);
	import udpdm_pkg::*;

	item_t    item;
	ram_req_t ram_req;
	ent_t     ram_rdata;
	res_t     res;
	logic     res_valid;
	logic     res_ready;
	logic     m_tvalid_q;
	res_t     out_q;

	assign item = item_t'(s_tdata);

	udpdm_sock_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (ram_rdata)
	);

	udpdm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item       (item),
		.func       (func_t'(s_tuser[1:0])),
		.first_byte (s_tuser[2]),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// load a new word whenever the output register is empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.buf_byte, out_q.buf_pos, out_q.sock_num};
	assign m_tuser  = {out_q.wake, out_q.write_valid};
	assign m_tlast  = out_q.last;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UDP port demux ring writer - testbench
// Drives datagram bytes, socket entry and reader position words with random
// gaps, and checks every ring write and idle word against a predictor of the
// header parser, socket lookup, ring space check and write positions.
// ----------------------------------------------------------------------------
module tb_top;
	import udpdm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DIRECTED_WORDS = 27;
	localparam int RANDOM_WORDS = 73;

	// Predicts the words of each accepted input and checks them in order.
	class demux_scoreboard;
		logic [17:0]      entry_tab[SOCKETS];
		logic [POS_W-1:0] wr_pos[SOCKETS];
		logic [POS_W-1:0] rd_pos[SOCKETS];
		int unsigned      byte_idx;
		logic [47:0]      hdr;
		int unsigned      cur_sock;
		bit               in_datagram;
		res_t             item_writes[$];
		res_t             expected_writes[$];
		int               errors;

		function new();
			foreach (entry_tab[i]) begin
				entry_tab[i] = '0;
				wr_pos[i] = '0;
				rd_pos[i] = '0;
			end
			byte_idx = 0;
			hdr = '0;
			cur_sock = 0;
			in_datagram = 0;
			errors = 0;
		endfunction

		function int outstanding();
			return expected_writes.size();
		endfunction

		function void ring_put(logic [7:0] b, bit wake_flag);
			res_t r;
			r.write_valid = 1'b1;
			r.sock_num = cur_sock[5:0];
			r.buf_pos = wr_pos[cur_sock];
			r.buf_byte = b;
			r.wake = wake_flag;
			r.last = 1'b0;
			item_writes.push_back(r);
			wr_pos[cur_sock] = wr_pos[cur_sock] + 1'b1;
		endfunction

		function void datagram_byte(logic first, item_t it);
			int unsigned idx;
			int unsigned ulen;
			int unsigned free_bytes;
			int unsigned w;
			int unsigned r;
			logic [15:0] sport;
			logic [15:0] dport;
			logic [15:0] plen;
			int hit;
			if (first) begin
				byte_idx = 0;
				hdr = '0;
				in_datagram = (it.datagram_len >= HDR_LEN);
			end
			if (!in_datagram)
				return;
			idx = byte_idx;
			if (byte_idx < 16'hFFFF)
				byte_idx++;
			if (idx < 6) begin
				hdr = {hdr[39:0], it.data_byte};
				return;
			end
			ulen = hdr[15:0];
			if (idx == 6)
				return;
			if (idx == 7) begin
				dport = hdr[31:16];
				sport = hdr[47:32];
				if (it.datagram_len < ulen || ulen < HDR_LEN) begin
					in_datagram = 0;
					return;
				end
				// first valid UDP entry bound to the port wins
				hit = -1;
				for (int i = 0; i < SOCKETS; i++)
					if (hit < 0 && entry_tab[i][17] && entry_tab[i][16] &&
							entry_tab[i][15:0] == dport)
						hit = i;
				if (hit < 0) begin
					in_datagram = 0;
					return;
				end
				cur_sock = hit;
				plen = 16'(ulen - HDR_LEN);
				w = wr_pos[cur_sock];
				r = rd_pos[cur_sock];
				free_bytes = (w >= r) ? BUF_BYTES - (w - r) : r - w;
				if (free_bytes <= plen + HDR_LEN + 1) begin
					in_datagram = 0;
					return;
				end
				ring_put(it.source_address[31:24], 1'b0);
				ring_put(it.source_address[23:16], 1'b0);
				ring_put(it.source_address[15:8], 1'b0);
				ring_put(it.source_address[7:0], 1'b0);
				ring_put(sport[7:0], 1'b0);
				ring_put(sport[15:8], 1'b0);
				ring_put(plen[7:0], 1'b0);
				ring_put(plen[15:8], plen == 0);
				if (plen == 0)
					in_datagram = 0;
				return;
			end
			if (idx >= ulen) begin
				in_datagram = 0;
				return;
			end
			ring_put(it.data_byte, idx + 1 == ulen);
			if (idx + 1 == ulen)
				in_datagram = 0;
		endfunction

		function void note_word(func_t f, logic first, item_t it);
			res_t r;
			item_writes.delete();
			case (f)
				FUNC_BYTE: begin
					datagram_byte(first, it);
				end
				FUNC_SET_ENTRY: begin
					entry_tab[it.sock_index] = {it.sock_valid, it.sock_is_udp, it.sock_port};
				end
				FUNC_READ_POS: begin
					rd_pos[it.sock_index] = it.read_pos;
				end
				default: begin
				end
			endcase
			if (item_writes.size() == 0) begin
				r = '0;
				item_writes.push_back(r);
			end
			foreach (item_writes[i]) begin
				r = item_writes[i];
				r.last = (i == item_writes.size() - 1);
				expected_writes.push_back(r);
			end
		endfunction

		function void check_word(res_t got);
			res_t want;
			if (expected_writes.size() == 0) begin
				$error("unexpected output word: sock_num %0d buf_pos %0d buf_byte %0d",
					got.sock_num, got.buf_pos, got.buf_byte);
				errors++;
				return;
			end
			want = expected_writes.pop_front();
			if (got.write_valid !== want.write_valid) begin
				$error("write_valid: expected %0d, got %0d", want.write_valid, got.write_valid);
				errors++;
			end
			if (got.sock_num !== want.sock_num) begin
				$error("sock_num: expected %0d, got %0d", want.sock_num, got.sock_num);
				errors++;
			end
			if (got.buf_pos !== want.buf_pos) begin
				$error("buf_pos: expected %0d, got %0d", want.buf_pos, got.buf_pos);
				errors++;
			end
			if (got.buf_byte !== want.buf_byte) begin
				$error("buf_byte: expected %0d, got %0d", want.buf_byte, got.buf_byte);
				errors++;
			end
			if (got.wake !== want.wake) begin
				$error("wake: expected %0d, got %0d", want.wake, got.wake);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	demux_scoreboard ring_check;
	int word_count;
	int idle_cycles;
	bit send_calm;
	bit recv_calm;

	udp_port_demux_ring_writer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Flip between calm stretches (no gaps) and stretches of random gaps.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 15) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic item_t rand_fields();
		item_t it;
		it = '0;
		it.data_byte = 8'($urandom);
		it.datagram_len = 16'($urandom);
		it.source_address = $urandom;
		it.sock_index = 6'($urandom);
		it.sock_valid = 1'($urandom);
		it.sock_is_udp = 1'($urandom);
		it.sock_port = 16'($urandom);
		it.read_pos = 10'($urandom);
		return it;
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 4))
			0: return 16'd53;
			1: return 16'd0;
			2: return 16'hFFFF;
			3: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Some socket that currently takes datagrams, or -1.
	function automatic int find_bound();
		int start;
		int s;
		start = $urandom_range(0, SOCKETS - 1);
		for (int k = 0; k < SOCKETS; k++) begin
			s = (start + k) % SOCKETS;
			if (ring_check.entry_tab[s][17] && ring_check.entry_tab[s][16])
				return s;
		end
		return -1;
	endfunction

	// Keep tvalid high when the next word follows with no gap.
	task automatic send_word(func_t f, logic first, item_t it);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it;
		s_tuser <= {first, f};
		do @(posedge clk); while (s_tready !== 1'b1);
		ring_check.note_word(f, first, it);
		word_count++;
	endtask

	task automatic set_entry(int idx, bit valid, bit udp, logic [15:0] port);
		item_t it;
		it = rand_fields();
		it.sock_index = idx[5:0];
		it.sock_valid = valid;
		it.sock_is_udp = udp;
		it.sock_port = port;
		send_word(FUNC_SET_ENTRY, 1'($urandom), it);
	endtask

	task automatic set_read_pos(int idx, logic [9:0] pos);
		item_t it;
		it = rand_fields();
		it.sock_index = idx[5:0];
		it.read_pos = pos;
		send_word(FUNC_READ_POS, 1'($urandom), it);
	endtask

	// Send nbytes words of a datagram; fewer than the header length aborts it.
	task automatic send_datagram(logic [15:0] sport, logic [15:0] dport, logic [15:0] ulen,
			logic [15:0] dlen, int nbytes, logic [31:0] src);
		logic [7:0] hb[8];
		item_t it;
		hb = '{sport[15:8], sport[7:0], dport[15:8], dport[7:0], ulen[15:8], ulen[7:0],
			8'($urandom), 8'($urandom)};
		for (int i = 0; i < nbytes; i++) begin
			it = rand_fields();
			it.datagram_len = dlen;
			it.source_address = src;
			if (i < 8)
				it.data_byte = hb[i];
			send_word(FUNC_BYTE, i == 0, it);
		end
	endtask

	// Drop tvalid so the last word is not taken twice, then wait for all results.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (ring_check.outstanding() != 0)
			@(posedge clk);
	endtask

	// Receiver: stall a random number of cycles before each word.
	initial begin : receiver
		int stall;
		m_tready = 1'b0;
		forever begin
			stall = draw_wait(recv_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n === 1'b1 && m_tvalid === 1'b1));
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got.write_valid = m_tuser[0];
			got.sock_num = m_tdata[5:0];
			got.buf_pos = m_tdata[15:6];
			got.buf_byte = m_tdata[23:16];
			got.wake = m_tuser[1];
			got.last = m_tlast;
			ring_check.check_word(got);
		end
	end

	// End the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int pick;
		int s;
		int plen;
		int ulen;
		int dlen;
		int nbytes;
		int extra;
		bit drained;
		logic [15:0] port;
		item_t it;

		ring_check = new();
		word_count = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		drained = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// invalid entry, non-UDP entry, then the entry that should match port 53
		set_entry(0, 1'b0, 1'b1, 16'd53);
		set_entry(5, 1'b1, 1'b0, 16'd53);
		set_entry(9, 1'b1, 1'b1, 16'd53);
		set_entry(63, 1'b1, 1'b1, 16'hFFFF);
		set_entry(20, 1'b1, 1'b1, 16'd0);
		it = rand_fields();
		send_word(FUNC_NONE, 1'b1, it);
		// byte outside any datagram
		it = rand_fields();
		send_word(FUNC_BYTE, 1'b0, it);
		set_read_pos(63, 10'd1023);
		// empty payload: wake on the last metadata write
		send_datagram(16'hFFFF, 16'd53, 16'd8, 16'd8, 8, 32'hFFFF_FFFF);
		// one payload byte, two trailing bytes past the UDP length
		send_datagram(16'h0000, 16'hFFFF, 16'd9, 16'd11, 11, 32'h0000_0000);
		drain();

		while (word_count < DIRECTED_WORDS + RANDOM_WORDS) begin
			if (!drained && word_count > DIRECTED_WORDS + RANDOM_WORDS / 2) begin
				drain();
				drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				s = find_bound();
				port = (s >= 0) ? ring_check.entry_tab[s][15:0] : pick_port();
				plen = $urandom_range(0, 6);
				ulen = HDR_LEN + plen;
				extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
				dlen = ulen + extra;
				nbytes = dlen;
				// cut it short so the next first byte aborts it
				if ($urandom_range(0, 9) == 0)
					nbytes = $urandom_range(1, dlen - 1);
				send_datagram(16'($urandom), port, 16'(ulen), 16'(dlen), nbytes, $urandom);
			end else if (pick < 65) begin
				case ($urandom_range(0, 4))
					0: send_datagram(16'($urandom), pick_port(), 16'($urandom),
						16'($urandom_range(0, HDR_LEN - 1)), $urandom_range(1, 4), $urandom);
					1: send_datagram(16'($urandom), pick_port(),
						16'($urandom_range(0, HDR_LEN - 1)), 16'($urandom_range(8, 40)), 8,
						$urandom);
					2: begin
						ulen = $urandom_range(9, 65535);
						send_datagram(16'($urandom), pick_port(), 16'(ulen),
							16'($urandom_range(8, ulen - 1)), 8, $urandom);
					end
					3: begin
						// payload that never fits the ring
						s = find_bound();
						port = (s >= 0) ? ring_check.entry_tab[s][15:0] : pick_port();
						send_datagram(16'($urandom), port, 16'($urandom_range(1025, 65535)),
							16'hFFFF, 9, $urandom);
					end
					default: begin
						ulen = $urandom_range(8, 14);
						send_datagram(16'($urandom), 16'($urandom), 16'(ulen), 16'(ulen),
							ulen, $urandom);
					end
				endcase
			end else if (pick < 78) begin
				set_entry($urandom_range(0, SOCKETS - 1), $urandom_range(0, 3) != 0,
					$urandom_range(0, 3) != 0, pick_port());
			end else if (pick < 92) begin
				s = find_bound();
				if (s < 0)
					s = $urandom_range(0, SOCKETS - 1);
				case ($urandom_range(0, 3))
					0, 1: set_read_pos(s, ring_check.wr_pos[s]);
					2: set_read_pos(s, ring_check.wr_pos[s] + 10'($urandom_range(1, 20)));
					default: set_read_pos(s, 10'($urandom));
				endcase
			end else begin
				it = rand_fields();
				send_word($urandom_range(0, 1) ? FUNC_NONE : FUNC_BYTE, 1'b0, it);
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (ring_check.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[udp_port_demux_ring_writer_top.f]
sv/udpdm_pkg.sv
sv/udpdm_sock_ram.sv
sv/udpdm_ctrl.sv
sv/udp_port_demux_ring_writer_top.sv
verif/tb_top.sv
